FILE: src/mvdp_pkg.sv
// Shared types, field widths and codes of the matrix-vector dot product block.
package mvdp_pkg;

  localparam int DATA_W     = 16;  // Q1.15 element
  localparam int PROD_W     = 32;  // Q2.30 lane product
  localparam int ACC_W      = 44;  // Q14.30 row sum
  localparam int ROW_W      = 13;  // row number field
  localparam int CFG_W      = 14;  // configuration data
  localparam int CFG_IDX_W  = 2;   // configuration register index
  localparam int GIDX_W     = 11;  // group_index field
  localparam int OUT_DATA_W = ((ACC_W + ROW_W + 7) / 8) * 8;

  localparam int DEF_MAX_LENGTH = 8192;
  localparam int DEF_LANES      = 4;
  localparam int LEN_RESET      = 8192;

  localparam logic [CFG_W-1:0] ROW_MAX = CFG_W'(8192);

  // Command codes carried on tuser.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ROW  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 2'd1;

  // Control that travels alongside one matrix group through the pipeline.
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [ROW_W-1:0] row;
  } mvdp_ctl_t;

endpackage

FILE: src/mvdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvdp_ram
  #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
  )
  (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/mvdp_lane.sv
// One multiply lane: masked signed Q1.15 x Q1.15 product, registered.
module mvdp_lane
  import mvdp_pkg::*;
  (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     mask,
    input  logic signed [DATA_W-1:0] mat,
    input  logic signed [DATA_W-1:0] vec,
    output logic signed [PROD_W-1:0] prod_r
  );

  logic signed [PROD_W-1:0] prod_nxt;

  // Drop lanes past the row end.
  assign prod_nxt = mask ? PROD_W'(mat * vec) : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

FILE: src/mvdp_merge.sv
// Merge stage: adds the lane products into the row accumulator, holds the result.
module mvdp_merge
  import mvdp_pkg::*;
  #(
    parameter int LANES = DEF_LANES
  )
  (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  mvdp_ctl_t                ctl,
    input  logic signed [PROD_W-1:0] prod [LANES],
    output logic                     out_valid_r,
    output logic signed [ACC_W-1:0]  dot_r,
    output logic [ROW_W-1:0]         row_r
  );

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] sum;

  always_comb begin
    sum = acc_r;
    for (int i = 0; i < LANES; i++) begin
      sum = sum + ACC_W'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl.vld && ctl.last;
      if (ctl.vld) begin
        acc_r <= ctl.last ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctl.vld && ctl.last) begin
      dot_r <= sum;
      row_r <= ctl.row;
    end
  end

endmodule

FILE: src/matrix_vector_dot_product.sv
// Top level of the matrix-vector dot product block (GEMV, one row at a time).
//
// Usage:
//   in_*  : stream of items. in_tuser is the command (load vector group or
//           supply matrix row group). in_tdata holds group_index and the lane
//           elements. A load writes LANES vector elements at group_index; a
//           matrix group is multiplied lane by lane with the stored group at
//           the current group position and added into the row sum.
//   out_* : one transfer per finished row, carrying the Q14.30 sum (exact but
//           for an all -1.0 full-length row, which wraps) and the row number.
//   cfg_* : register writes (vector_length, row_count), always ready. Write
//           them only while the block is idle.
// Throughput: one item per cycle while the output is not stalled. A row's last
//   group reaches out_tvalid through the operand and vector RAM read registers
//   (loaded at its transfer edge), then the lane multiply, then the merge add.
//   The merge add over all lanes sets the clock path.
// Reset: counters, accumulator and output valid clear; vector_length returns
//   to 8192 (clamped to MAX_LENGTH) and row_count to 8192. The vector RAM is not
//   cleared: load each group before a matrix group reads it.
// Stall: while out_tvalid waits without out_tready, the whole pipeline holds
//   and in_tready drops; it rises in the cycle the result is taken.
module matrix_vector_dot_product
  import mvdp_pkg::*;
  #(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH,
    parameter int LANES      = DEF_LANES,
    localparam int IN_DATA_W = ((GIDX_W + LANES * DATA_W + 7) / 8) * 8
  )
  (
    input  logic                  clk,
    input  logic                  rst_n,
    // in_tdata: group_index, value_lane0 .. value_lane(LANES-1), zero pad
    input  logic [IN_DATA_W-1:0]  in_tdata,
    // in_tuser: command
    input  logic                  in_tuser,
    input  logic                  in_tvalid,
    output logic                  in_tready,
    // out_tdata: dot_value, row_number, zero pad
    output logic [OUT_DATA_W-1:0] out_tdata,
    output logic                  out_tvalid,
    input  logic                  out_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
  );

  localparam int GROUPS  = MAX_LENGTH / LANES;
  localparam int GA_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int LEN_W   = $clog2(MAX_LENGTH + 1);
  localparam int POS_W   = $clog2(MAX_LENGTH + LANES + 1);
  localparam int LW      = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int GI_W    = ((GA_W > GIDX_W) ? GA_W : GIDX_W) + 1;
  localparam int RST_LEN = (LEN_RESET > MAX_LENGTH) ? MAX_LENGTH : LEN_RESET;
  localparam int VEC_W   = LANES * DATA_W;

  // ---------------------------------------------------------------- config
  logic [LEN_W-1:0] len_eff_r, len_eff_nxt;
  logic [CFG_W-1:0] rows_eff_r, rows_eff_nxt;
  logic [LW-1:0]    cfg_ext;

  assign cfg_ready = 1'b1;
  assign cfg_ext   = LW'(cfg_data);

  // Clamp lengths and row counts into their legal range at write time.
  always_comb begin
    len_eff_nxt  = len_eff_r;
    rows_eff_nxt = rows_eff_r;
    if (cfg_valid && cfg_index == REG_VECTOR_LENGTH) begin
      priority if (cfg_data == '0) begin
        len_eff_nxt = LEN_W'(1);
      end else if (cfg_ext > LW'(MAX_LENGTH)) begin
        len_eff_nxt = LEN_W'(MAX_LENGTH);
      end else begin
        len_eff_nxt = LEN_W'(cfg_ext);
      end
    end
    if (cfg_valid && cfg_index == REG_ROW_COUNT) begin
      priority if (cfg_data == '0) begin
        rows_eff_nxt = CFG_W'(1);
      end else if (cfg_data > ROW_MAX) begin
        rows_eff_nxt = ROW_MAX;
      end else begin
        rows_eff_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_eff_r  <= LEN_W'(RST_LEN);
      rows_eff_r <= ROW_MAX;
    end else begin
      len_eff_r  <= len_eff_nxt;
      rows_eff_r <= rows_eff_nxt;
    end
  end

  // ------------------------------------------------------- accept / control
  logic             en;
  logic             in_xfer;
  logic             row_xfer;
  logic             load_we;
  logic             fin;
  logic [GI_W-1:0]  gi_ext;
  logic [GA_W-1:0]  g_r, g_nxt;
  logic [POS_W-1:0] base_r, base_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CFG_W-1:0] row_inc;
  logic [LANES-1:0] mask;

  // The pipeline advances whenever the output register is free or drains.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign in_xfer   = in_tvalid && in_tready;
  assign row_xfer  = in_xfer && (in_tuser == CMD_ROW);

  // Loads beyond the store are dropped.
  assign gi_ext  = GI_W'(in_tdata[GIDX_W-1:0]);
  assign load_we = in_xfer && (in_tuser == CMD_LOAD) && (gi_ext < GI_W'(GROUPS));

  // The row ends when this group reaches or passes the configured length.
  assign fin = (base_r + POS_W'(LANES)) >= POS_W'(len_eff_r);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mask[l] = (base_r + POS_W'(l)) < POS_W'(len_eff_r);
    end
  end

  assign row_inc = CFG_W'(row_r) + CFG_W'(1);

  always_comb begin
    g_nxt    = g_r;
    base_nxt = base_r;
    row_nxt  = row_r;
    if (row_xfer) begin
      if (fin) begin
        g_nxt    = '0;
        base_nxt = '0;
        row_nxt  = (row_inc >= rows_eff_r) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        g_nxt    = g_r + GA_W'(1);
        base_nxt = base_r + POS_W'(LANES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r    <= '0;
      base_r <= '0;
      row_r  <= '0;
    end else begin
      g_r    <= g_nxt;
      base_r <= base_nxt;
      row_r  <= row_nxt;
    end
  end

  // ------------------------------------------------------------ vector RAM
  logic [VEC_W-1:0] vec_rdata;

  mvdp_ram #(
    .WIDTH (VEC_W),
    .DEPTH (GROUPS),
    .ADDR_W(GA_W)
  ) u_vec_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(gi_ext[GA_W-1:0]),
    .wdata(in_tdata[GIDX_W +: VEC_W]),
    .re   (row_xfer),
    .raddr(g_r),
    .rdata(vec_rdata)
  );

  // ------------------------------------------------------ stage 1: operands
  mvdp_ctl_t                s1_ctl_r;
  mvdp_ctl_t                s2_ctl_r;
  logic signed [DATA_W-1:0] s1_mat_r [LANES];
  logic [LANES-1:0]         s1_mask_r;
  logic signed [PROD_W-1:0] prod [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r.vld  <= row_xfer;
      s1_ctl_r.last <= fin;
      s1_ctl_r.row  <= row_r;
      s2_ctl_r      <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mask_r <= mask;
      for (int l = 0; l < LANES; l++) begin
        s1_mat_r[l] <= in_tdata[GIDX_W + l * DATA_W +: DATA_W];
      end
    end
  end

  // ---------------------------------------------------- stage 2: multiply
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    mvdp_lane u_lane (
      .clk   (clk),
      .en    (en),
      .mask  (s1_mask_r[l]),
      .mat   (s1_mat_r[l]),
      .vec   (vec_rdata[l * DATA_W +: DATA_W]),
      .prod_r(prod[l])
    );
  end

  // ------------------------------------------------------- stage 3: merge
  logic signed [ACC_W-1:0] dot;
  logic [ROW_W-1:0]        out_row;

  mvdp_merge #(
    .LANES(LANES)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .ctl        (s2_ctl_r),
    .prod       (prod),
    .out_valid_r(out_tvalid),
    .dot_r      (dot),
    .row_r      (out_row)
  );

  assign out_tdata = {{(OUT_DATA_W - ACC_W - ROW_W){1'b0}}, out_row, dot};

  // ------------------------------------------------------------ assertions
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while the result is stalled");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s2_ctl_r.vld && s2_ctl_r.last))
    else $error("result without a row-final group");

  a_load_not_in_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_LOAD |=> !s1_ctl_r.vld)
    else $error("load item entered the multiply pipeline");

endmodule

FILE: sim/matrix_vector_dot_product_tb.sv
// Testbench for matrix_vector_dot_product: streams vector loads and matrix groups, checks row sums.
`timescale 1ns / 100ps

module matrix_vector_dot_product_tb;
  import mvdp_pkg::*;

  localparam int NUM_LANES  = 4;
  localparam int NUM_GROUPS = DEF_MAX_LENGTH / NUM_LANES;
  localparam int IN_DATA_W  = ((GIDX_W + NUM_LANES * DATA_W + 7) / 8) * 8;
  localparam int IN_PAD_W   = IN_DATA_W - GIDX_W - NUM_LANES * DATA_W;
  // A row result follows its last group through the pipeline registers; leave
  // some margin before touching registers.
  localparam int SETTLE_CYCLES = 8;

  typedef logic [NUM_LANES-1:0][DATA_W-1:0] group_t;

  typedef struct {
    logic [ACC_W-1:0] dot;
    logic [ROW_W-1:0] row;
  } row_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  // in_tdata: group_index, value_lane0, value_lane1, value_lane2, value_lane3, zero pad
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // in_tuser: command
  logic                  in_tuser = CMD_LOAD;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // out_tdata: dot_value, row_number, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_VECTOR_LENGTH;
  logic [CFG_W-1:0]      cfg_data = '0;

  matrix_vector_dot_product DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow state of the block, updated at each accepted transfer.
  group_t           vec_store [NUM_GROUPS];
  bit               loaded    [NUM_GROUPS];
  logic [ACC_W-1:0] row_sum   = '0;
  logic [GIDX_W-1:0] grp_pos  = '0;
  logic [ROW_W-1:0] row_num   = '0;
  logic [CFG_W-1:0] cur_len   = CFG_W'(LEN_RESET);
  logic [CFG_W-1:0] cur_rows  = ROW_MAX;

  row_result_t pending_rows[$];

  int send_idle = 0;
  int recv_idle = 0;
  int hold_cnt = 0;
  int mismatches = 0;
  int items_sent = 0;
  int rows_checked = 0;
  int reg_writes = 0;

  // ---------------------------------------------------------------------------
  // Row-sum predictor: apply one accepted item to the shadow state and queue
  // the finished row, if any.
  // ---------------------------------------------------------------------------
  task automatic accumulate_row(input logic cmd, input logic [GIDX_W-1:0] gidx,
                                input group_t vals);
    int          eff_len;
    int          eff_rows;
    int          last_grp;
    int          pos;
    int          next_row;
    logic [63:0] acc;
    longint      prod;
    row_result_t done;
    if (cmd == CMD_LOAD) begin
      // group_index is 11 bits, so every load lands inside the store
      vec_store[gidx] = vals;
      loaded[gidx] = 1'b1;
      return;
    end
    // Clamp register values the way the block does: 0 acts as 1, big values saturate.
    eff_len  = (cur_len == 0) ? 1 : (cur_len > DEF_MAX_LENGTH) ? DEF_MAX_LENGTH : int'(cur_len);
    eff_rows = (cur_rows == 0) ? 1 : (cur_rows > ROW_MAX) ? int'(ROW_MAX) : int'(cur_rows);
    last_grp = (eff_len + NUM_LANES - 1) / NUM_LANES - 1;
    acc = {{(64-ACC_W){1'b0}}, row_sum};
    for (int l = 0; l < NUM_LANES; l++) begin
      pos = int'(grp_pos) * NUM_LANES + l;
      // Lanes past the vector length contribute nothing.
      if (pos < eff_len) begin
        prod = longint'($signed(vals[l])) * longint'($signed(vec_store[grp_pos][l]));
        acc = acc + 64'(prod);
      end
    end
    // Keep the sum at the accumulator width; only an all -1.0 full-length row wraps.
    if (int'(grp_pos) >= last_grp) begin
      done.dot = acc[ACC_W-1:0];
      done.row = row_num;
      pending_rows.push_back(done);
      row_sum = '0;
      grp_pos = '0;
      next_row = int'(row_num) + 1;
      row_num = (next_row >= eff_rows) ? '0 : ROW_W'(next_row);
    end else begin
      row_sum = acc[ACC_W-1:0];
      grp_pos = grp_pos + 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare each result transfer with the oldest expected row.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 100)
      $display("MISMATCH %s at %0t: got 0x%0h, expected 0x%0h", what, $realtime, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, '0);
      end else begin
        want = pending_rows.pop_front();
        if (out_tdata[ACC_W-1:0] !== want.dot)
          report_mismatch("dot_value", out_tdata[ACC_W-1:0], want.dot);
        if (out_tdata[ACC_W +: ROW_W] !== want.row)
          report_mismatch("row_number", out_tdata[ACC_W +: ROW_W], want.row);
        rows_checked++;
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Drive one item and hold it until the transfer; valid stays high afterwards
  // so a following item can go back to back.
  task automatic send_item(input logic cmd, input logic [GIDX_W-1:0] gidx,
                           input group_t vals);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tuser  <= cmd;
    in_tdata  <= {{IN_PAD_W{1'b0}}, vals, gidx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    accumulate_row(cmd, gidx, vals);
    items_sent++;
  endtask

  task automatic bus_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Pause input until every row is out, then let the pipeline settle.
  task automatic wait_drain();
    bus_idle();
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_VECTOR_LENGTH) cur_len = val;
    else if (idx == REG_ROW_COUNT) cur_rows = val;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rand_elem();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return DATA_W'($urandom);
  endfunction

  function automatic group_t rand_group();
    group_t g;
    for (int l = 0; l < NUM_LANES; l++) g[l] = rand_elem();
    return g;
  endfunction

  // Send one matrix group; load the store entry it reads first if it was never written.
  task automatic send_row_group(input group_t vals);
    if (!loaded[grp_pos]) send_item(CMD_LOAD, grp_pos, rand_group());
    send_item(CMD_ROW, GIDX_W'($urandom), vals);
  endtask

  // Load a fresh vector covering the current length.
  task automatic load_vector();
    int groups;
    groups = (cur_len == 0) ? 1 :
             (cur_len > DEF_MAX_LENGTH) ? NUM_GROUPS : (int'(cur_len) + NUM_LANES - 1) / NUM_LANES;
    for (int i = 0; i < groups; i++) send_item(CMD_LOAD, GIDX_W'(i), rand_group());
  endtask

  function automatic logic [CFG_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 80) return CFG_W'($urandom_range(1, 48));
    return CFG_W'($urandom_range(49, 400));
  endfunction

  function automatic logic [CFG_W-1:0] pick_rows();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return CFG_W'($urandom_range(1, 12));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values of both registers: a stretch of -1.0 x -1.0 groups keeps
  // adding without closing the row, then a short length closes it.
  task automatic test_reset_registers();
    for (int i = 0; i < 12; i++)
      send_item(CMD_LOAD, GIDX_W'(i), {NUM_LANES{16'h8000}});
    for (int i = 0; i < 12; i++)
      send_item(CMD_ROW, GIDX_W'($urandom), {NUM_LANES{16'h8000}});
    wait_drain();
    write_reg(REG_VECTOR_LENGTH, CFG_W'(4));
    send_row_group({NUM_LANES{16'h7FFF}});
    wait_drain();
  endtask

  // Field extremes, a partial tail group, row number wrap, and register
  // values of zero.
  task automatic test_lengths_and_wrap();
    write_reg(REG_VECTOR_LENGTH, CFG_W'(7));
    write_reg(REG_ROW_COUNT, CFG_W'(3));
    send_item(CMD_LOAD, '0, {16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF});
    send_item(CMD_LOAD, GIDX_W'(1), {16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000});
    // Rows finish every second group; the row number wraps after three.
    send_item(CMD_ROW, '1, {NUM_LANES{16'h7FFF}});
    send_item(CMD_ROW, '0, {NUM_LANES{16'h7FFF}});
    send_item(CMD_ROW, '1, {NUM_LANES{16'h8000}});
    send_item(CMD_ROW, '0, {NUM_LANES{16'h8000}});
    send_item(CMD_ROW, '0, '0);
    send_item(CMD_ROW, '0, '0);
    send_item(CMD_ROW, '1, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001});
    send_item(CMD_ROW, '1, {16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000});
    wait_drain();
    // Zero in both registers acts as one: every group is a row, always row 0.
    write_reg(REG_VECTOR_LENGTH, '0);
    write_reg(REG_ROW_COUNT, '0);
    send_item(CMD_ROW, '0, {NUM_LANES{16'h8000}});
    send_item(CMD_ROW, '0, {NUM_LANES{16'h7FFF}});
    send_item(CMD_ROW, '1, rand_group());
    wait_drain();
    // Length that fills whole groups exactly.
    write_reg(REG_VECTOR_LENGTH, CFG_W'(4));
    write_reg(REG_ROW_COUNT, CFG_W'(1));
    send_item(CMD_ROW, '0, {NUM_LANES{16'h7FFF}});
    send_item(CMD_ROW, '0, {NUM_LANES{16'h8000}});
    wait_drain();
    write_reg(REG_VECTOR_LENGTH, CFG_W'(1));
    send_item(CMD_ROW, '0, {16'h1234, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    wait_drain();
  endtask

  // Register values above the legal range act as the maximum, so the row
  // runs on until a short length closes it.
  task automatic test_length_above_range();
    write_reg(REG_VECTOR_LENGTH, '1);
    write_reg(REG_ROW_COUNT, '1);
    for (int i = 0; i < 16; i++) send_row_group(rand_group());
    wait_drain();
    write_reg(REG_VECTOR_LENGTH, CFG_W'(8));
    send_row_group(rand_group());
    wait_drain();
  endtask

  // Shorten the length in the middle of a row so the next group closes it,
  // then lengthen it mid-row so the row runs on.
  task automatic test_length_change_mid_row();
    write_reg(REG_ROW_COUNT, ROW_MAX);
    write_reg(REG_VECTOR_LENGTH, CFG_W'(40));
    repeat (6) send_row_group(rand_group());
    wait_drain();
    write_reg(REG_VECTOR_LENGTH, CFG_W'(20));
    send_row_group(rand_group());
    repeat (5) send_row_group(rand_group());
    wait_drain();
    write_reg(REG_VECTOR_LENGTH, CFG_W'(8));
    send_row_group(rand_group());
    wait_drain();
    write_reg(REG_VECTOR_LENGTH, CFG_W'(16));
    repeat (3) send_row_group(rand_group());
    wait_drain();
  endtask

  // Hold the output off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    write_reg(REG_VECTOR_LENGTH, CFG_W'(4));
    write_reg(REG_ROW_COUNT, CFG_W'(5));
    send_item(CMD_LOAD, '0, rand_group());
    hold_cnt = 400;
    repeat (60) send_row_group(rand_group());
    wait_drain();
  endtask

  // Mostly well-formed traffic under random settings, with stray loads and
  // loads into the entry about to be read.
  task automatic run_random_phase(input int count);
    int stop_at;
    int next_cfg;
    int r;
    stop_at  = items_sent + count;
    next_cfg = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_cfg) begin
        wait_drain();
        write_reg(REG_VECTOR_LENGTH, pick_length());
        write_reg(REG_ROW_COUNT, pick_rows());
        if ($urandom_range(1)) load_vector();
        next_cfg = items_sent + $urandom_range(60, 140);
      end
      r = $urandom_range(99);
      if (r < 82) send_row_group(rand_group());
      else if (r < 90) send_item(CMD_LOAD, grp_pos, rand_group());
      else send_item(CMD_LOAD, GIDX_W'($urandom), rand_group());
    end
  endtask

  task automatic test_random();
    send_idle = 26;
    recv_idle = 61;
    run_random_phase(330);
    send_idle = 61;
    recv_idle = 26;
    run_random_phase(330);
    send_idle = 0;
    recv_idle = 0;
    run_random_phase(330);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle = 26;
    recv_idle = 61;
    test_reset_registers();
    test_lengths_and_wrap();
    test_length_above_range();
    test_length_change_mid_row();
    test_backpressure();
    test_random();
    wait_drain();
    $display("Sent %0d items, checked %0d row results, made %0d register writes.",
             items_sent, rows_checked, reg_writes);
    $display("Covered reset lengths, clamped registers, partial tails, row wrap,");
    $display("mid-row length changes and long output stalls.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d rows still expected", pending_rows.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
